>>> rtl/core/psxad_pkg.sv
// ----------------------------------------------------------------------------
// psxad_pkg
// Shared constants, types and coefficient tables for the ADPCM frame decoder.
// ----------------------------------------------------------------------------
package psxad_pkg;

  localparam int FRAME_BYTES        = 16;
  localparam int POS_W              = 4;
  localparam int HIST_W             = 40;
  localparam int COEF_W             = 8;
  localparam int PROD_W             = HIST_W + COEF_W;
  localparam int SUM_W              = PROD_W + 1;
  localparam int PRED_SHIFT         = 6;
  localparam int SAMPLE_W           = 16;
  localparam int NIB_W              = 4;
  localparam int BYTE_W             = 8;
  localparam int MAX_CHANNELS_DEF   = 2;
  localparam int FRAC_BITS_DEF      = 16;

  localparam logic [BYTE_W-1:0] FLAGS_END = 8'd7;

  typedef struct packed {
    logic latch;
    logic step;
    logic mul;
    logic acc;
    logic nib_sel;
    logic emit_data;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic is_header;
    logic is_flags;
    logic end_flag;
    logic ended;
    logic out_free;
  } status_t;

  function automatic logic signed [COEF_W-1:0] coef_k0(input logic [NIB_W-1:0] f);
    logic signed [COEF_W-1:0] k;
    case (f)
      4'd1:    k = 8'sd60;
      4'd2:    k = 8'sd115;
      4'd3:    k = 8'sd98;
      4'd4:    k = 8'sd122;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_k1(input logic [NIB_W-1:0] f);
    logic signed [COEF_W-1:0] k;
    case (f)
      4'd2:    k = -8'sd52;
      4'd3:    k = -8'sd55;
      4'd4:    k = -8'sd60;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/psxad_ctrl.sv
// ----------------------------------------------------------------------------
// psxad_ctrl
// Sequencer: takes one item, classifies it, runs the two nibble decodes of a
// data byte and hands the result, or an end marker, to the output register.
// ----------------------------------------------------------------------------
module psxad_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  psxad_pkg::status_t st,
  output psxad_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_MUL0 = 3'd2;
  localparam logic [2:0] S_ACC0 = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_ACC1 = 3'd5;
  localparam logic [2:0] S_EMTD = 3'd6;
  localparam logic [2:0] S_EMTE = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (st.is_header) begin
          state_nxt = S_IDLE;
        end else if (st.is_flags) begin
          state_nxt = st.end_flag ? S_EMTE : S_IDLE;
        end else if (st.ended) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC0;
      end
      S_ACC0: begin
        cmd.acc   = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul     = 1'b1;
        cmd.nib_sel = 1'b1;
        state_nxt   = S_ACC1;
      end
      S_ACC1: begin
        cmd.acc     = 1'b1;
        cmd.nib_sel = 1'b1;
        state_nxt   = S_EMTD;
      end
      S_EMTD: begin
        if (st.out_free) begin
          cmd.emit_data = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EMTE: begin
        if (st.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/psxad_dp.sv
// ----------------------------------------------------------------------------
// psxad_dp
// Datapath: per-channel frame state, prediction filter, history update,
// output rounding and the output register.
// ----------------------------------------------------------------------------
module psxad_dp #(
  parameter int MAX_CHANNELS          = psxad_pkg::MAX_CHANNELS_DEF,
  parameter int HISTORY_FRACTION_BITS = psxad_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psxad_pkg::cmd_t    cmd,
  output psxad_pkg::status_t st,
  input  logic [7:0]         in_tdata,
  input  logic [1:0]         in_tuser,
  input  logic               cfg_valid,
  input  logic [0:0]         cfg_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic [0:0]         out_tuser,
  output logic               out_tlast
);

  localparam int HW  = psxad_pkg::HIST_W;
  localparam int F   = HISTORY_FRACTION_BITS;
  localparam int SW  = psxad_pkg::SAMPLE_W;
  localparam logic [HW:0] ROUND_HALF = (HW+1)'(1) << (F - 1);
  localparam logic [HW:0] FRAC_MASK  = ((HW+1)'(1) << F) - (HW+1)'(1);

  logic                                stereo_r;
  logic [psxad_pkg::BYTE_W-1:0]        byte_r;
  logic                                ch_r;
  logic                                restart_r;

  logic signed [HW-1:0]                hist_rec_r [MAX_CHANNELS];
  logic signed [HW-1:0]                hist_old_r [MAX_CHANNELS];
  logic [psxad_pkg::POS_W-1:0]         pos_r      [MAX_CHANNELS];
  logic [psxad_pkg::NIB_W-1:0]         shift_r    [MAX_CHANNELS];
  logic [psxad_pkg::NIB_W-1:0]         filt_r     [MAX_CHANNELS];
  logic                                ended_r    [MAX_CHANNELS];

  logic signed [psxad_pkg::PROD_W-1:0] prod0_r;
  logic signed [psxad_pkg::PROD_W-1:0] prod1_r;

  logic                                out_tvalid_r;
  logic [31:0]                         out_tdata_r;
  logic                                out_tuser_r;
  logic                                out_tlast_r;

  logic [psxad_pkg::POS_W-1:0]         pos_eff;
  logic                                ended_eff;
  logic [psxad_pkg::POS_W-1:0]         pos_nxt;
  logic                                ended_nxt;
  logic signed [psxad_pkg::COEF_W-1:0] k0;
  logic signed [psxad_pkg::COEF_W-1:0] k1;
  logic signed [psxad_pkg::PROD_W-1:0] prod0;
  logic signed [psxad_pkg::PROD_W-1:0] prod1;
  logic signed [psxad_pkg::SUM_W-1:0]  sum;
  logic [HW-1:0]                       pred;
  logic [psxad_pkg::NIB_W-1:0]         nib;
  logic signed [SW-1:0]                raw;
  logic [HW-1:0]                       raw_scaled;
  logic signed [HW-1:0]                hist_nxt;
  logic [SW-1:0]                       q_first;
  logic [SW-1:0]                       q_second;

  function automatic logic [SW-1:0] round_out(input logic signed [HW-1:0] h);
    logic signed [HW:0] t;
    logic signed [HW:0] fl;
    logic               adj;
    t   = $signed({h[HW-1], h}) + $signed(ROUND_HALF);
    fl  = t >>> F;
    adj = t[HW] & (|(t & FRAC_MASK));
    return fl[SW-1:0] + {{(SW-1){1'b0}}, adj};
  endfunction

  // restart acts before the byte is used
  assign pos_eff   = restart_r ? '0 : pos_r[ch_r];
  assign ended_eff = restart_r ? 1'b0 : ended_r[ch_r];

  assign st.is_header = (pos_eff == '0);
  assign st.is_flags  = (pos_eff == psxad_pkg::POS_W'(1));
  assign st.end_flag  = (byte_r == psxad_pkg::FLAGS_END);
  assign st.ended     = ended_eff;
  assign st.out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    ended_nxt = ended_eff;
    if (st.is_header) begin
      ended_nxt = 1'b0;
    end else if (st.is_flags && st.end_flag) begin
      ended_nxt = 1'b1;
    end
    if (pos_eff == psxad_pkg::POS_W'(psxad_pkg::FRAME_BYTES - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_eff + psxad_pkg::POS_W'(1);
    end
  end

  // prediction products
  assign k0    = psxad_pkg::coef_k0(filt_r[ch_r]);
  assign k1    = psxad_pkg::coef_k1(filt_r[ch_r]);
  assign prod0 = hist_rec_r[ch_r] * k0;
  assign prod1 = hist_old_r[ch_r] * k1;

  // accumulate, floor shift, add scaled nibble, wrap to history width
  assign sum        = prod0_r + prod1_r;
  assign pred       = sum[HW+psxad_pkg::PRED_SHIFT-1:psxad_pkg::PRED_SHIFT];
  assign nib        = cmd.nib_sel ? byte_r[7:4] : byte_r[3:0];
  assign raw        = $signed({nib, 12'b0}) >>> shift_r[ch_r];
  assign raw_scaled = {{(HW-SW){raw[SW-1]}}, raw} << F;
  assign hist_nxt   = $signed(raw_scaled + pred);

  assign q_first  = round_out(hist_old_r[ch_r]);
  assign q_second = round_out(hist_rec_r[ch_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b0;
    end else if (cfg_valid) begin
      stereo_r <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_r    <= in_tdata;
      restart_r <= in_tuser[1];
      ch_r      <= (stereo_r && MAX_CHANNELS > 1) ? in_tuser[0] : 1'b0;
    end
    if (cmd.mul) begin
      prod0_r <= prod0;
      prod1_r <= prod1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_rec_r[i] <= '0;
        hist_old_r[i] <= '0;
        pos_r[i]      <= '0;
        shift_r[i]    <= '0;
        filt_r[i]     <= '0;
        ended_r[i]    <= 1'b0;
      end
    end else begin
      if (cmd.step) begin
        pos_r[ch_r]   <= pos_nxt;
        ended_r[ch_r] <= ended_nxt;
        if (restart_r) begin
          hist_rec_r[ch_r] <= '0;
          hist_old_r[ch_r] <= '0;
        end
        if (st.is_header) begin
          filt_r[ch_r]  <= byte_r[7:4];
          shift_r[ch_r] <= byte_r[3:0];
        end
      end
      if (cmd.acc) begin
        hist_old_r[ch_r] <= hist_rec_r[ch_r];
        hist_rec_r[ch_r] <= hist_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit_data || cmd.emit_end) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      out_tdata_r <= {q_second, q_first};
      out_tuser_r <= ch_r;
      out_tlast_r <= 1'b0;
    end else if (cmd.emit_end) begin
      out_tdata_r <= '0;
      out_tuser_r <= ch_r;
      out_tlast_r <= 1'b1;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;
  assign out_tlast    = out_tlast_r;

endmodule

>>> rtl/core/psx_adpcm_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// psx_adpcm_frame_decoder_unit
// ADPCM frame decoder, one frame byte per input item.
// ----------------------------------------------------------------------------
// Input channel (in_*): one raw frame byte per item, with its channel and a
// restart flag in tuser. Output channel (out_*): two decoded 16-bit samples
// per data byte, or an end marker (tlast) with zero samples when a frame's
// flags byte is 7. Header, non-end flags and bytes after an end give nothing.
// cfg_*: stereo_mode write, always ready; write it only with no item in work.
// Sequence: a header or flags byte passes the step state and frees the block;
// an end marker passes the step state, then loads the output register, and
// the next item is taken in the following cycle; a data byte passes the step
// state, then the two dependent prediction steps (multiply, then accumulate)
// run for each nibble in turn on one filter before the output register loads.
// One item is in work at a time. The result sits in an output register, so
// the next item is taken while it waits; a stalled receiver only holds the
// block when the next result is ready to load.
// Reset (rst_n low, synchronous): history, frame position, shift, filter,
// end marks and stereo_mode are cleared, the output register is emptied.
// ----------------------------------------------------------------------------
module psx_adpcm_frame_decoder_unit #(
  parameter int MAX_CHANNELS          = psxad_pkg::MAX_CHANNELS_DEF,
  parameter int HISTORY_FRACTION_BITS = psxad_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] frame_byte
  input  logic [1:0]  in_tuser,    // [0] channel, [1] restart
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,    // [0] stereo_mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] first_sample, [31:16] second_sample
  output logic [0:0]  out_tuser,   // [0] out_channel
  output logic        out_tlast    // stream_end
);

  psxad_pkg::cmd_t    cmd;
  psxad_pkg::status_t st;

  assign cfg_ready = 1'b1;

  psxad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  psxad_dp #(
    .MAX_CHANNELS          (MAX_CHANNELS),
    .HISTORY_FRACTION_BITS (HISTORY_FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
